FILE: hw/rtl/edpc_pkg.sv
// ----------------------------------------------------------------------------
// edpc_pkg
// Shared widths, constants and beat types for the encoder detent and
// press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package edpc_pkg;

	localparam int unsigned CNT_W       = 16;
	localparam int unsigned DET_W       = 15;
	localparam int unsigned TIME_W      = 48;
	localparam int unsigned CFG_W       = 16;
	localparam int unsigned THR_W       = 26;
	localparam int unsigned IN_TDATA_W  = 72;
	localparam int unsigned OUT_TDATA_W = 24;

	localparam int unsigned DETENT_STEP_DEF   = 4;
	localparam int unsigned LONG_PRESS_MS_RST = 600;
	localparam int unsigned US_PER_MS         = 1000;

	localparam logic [CNT_W-1:0] DET_POS_LIM = CNT_W'(16383);
	localparam logic [CNT_W-1:0] DET_NEG_LIM = CNT_W'(16384);

	typedef struct packed {
		logic [TIME_W-1:0]       time_us;
		logic                    button_level;
		logic signed [CNT_W-1:0] pulse_count;
	} in_beat_t;

	localparam int unsigned IN_FIELDS_W = $bits(in_beat_t);

	typedef struct packed {
		logic                    long_press;
		logic                    short_press;
		logic signed [DET_W-1:0] detents;
	} out_beat_t;

	localparam int unsigned OUT_FIELDS_W = $bits(out_beat_t);

endpackage

`default_nettype wire

FILE: hw/rtl/edpc_detent.sv
// ----------------------------------------------------------------------------
// edpc_detent
// Signed count difference divided by the detent step (toward zero) through
// an exact reciprocal multiply, saturated, with the advanced reference.
// ----------------------------------------------------------------------------
`default_nettype none

module edpc_detent #(
	parameter int unsigned DETENT_STEP = edpc_pkg::DETENT_STEP_DEF
) (
	input  wire logic signed [edpc_pkg::CNT_W-1:0] pulse_count,
	input  wire logic signed [edpc_pkg::CNT_W-1:0] ref_count,
	output logic signed [edpc_pkg::DET_W-1:0]      detents,
	output logic signed [edpc_pkg::CNT_W-1:0]      ref_next
);
	import edpc_pkg::*;

	localparam int unsigned SHIFT   = CNT_W + $clog2(DETENT_STEP);
	localparam int unsigned RECIP_W = CNT_W + 1;
	localparam int unsigned PROD_W  = CNT_W + RECIP_W;
	localparam longint unsigned RECIP_V =
		((64'd1 << SHIFT) + DETENT_STEP - 1) / DETENT_STEP;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_V);
	localparam logic signed [CNT_W+1:0] CPD_S = (CNT_W+2)'(DETENT_STEP);

	logic signed [CNT_W:0]   delta;
	logic                    neg;
	logic [CNT_W:0]          mag_w;
	logic [CNT_W-1:0]        mag;
	logic [PROD_W-1:0]       prod;
	logic [CNT_W-1:0]        quo;
	logic [CNT_W-1:0]        quo_sat;
	logic signed [CNT_W-1:0] det_w;
	logic signed [CNT_W+1:0] step;
	logic signed [CNT_W+1:0] ref_sum;

	always_comb begin
		delta   = (CNT_W+1)'(pulse_count) - (CNT_W+1)'(ref_count);
		neg     = delta[CNT_W];
		mag_w   = neg ? -delta : delta;
		mag     = mag_w[CNT_W-1:0];
		prod    = PROD_W'(mag) * PROD_W'(RECIP);
		quo     = CNT_W'(prod >> SHIFT);
		if (neg) begin
			quo_sat = (quo > DET_NEG_LIM) ? DET_NEG_LIM : quo;
			det_w   = -$signed(quo_sat);
		end else begin
			quo_sat = (quo > DET_POS_LIM) ? DET_POS_LIM : quo;
			det_w   = $signed(quo_sat);
		end
		detents = det_w[DET_W-1:0];
		step    = (CNT_W+2)'(det_w) * CPD_S;
		ref_sum = (CNT_W+2)'(ref_count) + step;
		ref_next = ref_sum[CNT_W-1:0];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/encoder_detent_and_press_classifier_core.sv
// ----------------------------------------------------------------------------
// encoder_detent_and_press_classifier_core
// Path from input beat to result beat: input register, result register;
// one result beat per input beat.
// Throughput: one beat per cycle unless m_tready stalls the result beat,
// set by the reference and button state update between the two registers.
// Reset: reference 0, button released, long-press threshold 600 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_detent_and_press_classifier_core #(
	parameter int unsigned DETENT_STEP = edpc_pkg::DETENT_STEP_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [edpc_pkg::CFG_W-1:0]        cfg_wdata,   // hold threshold in ms
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// pulse_count[15:0], button_level[16], time_us[64:17], zero pad
	input  wire logic [edpc_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  wire logic                              s_tuser,     // count_valid
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// detents[14:0], short_press[15], long_press[16], zero pad
	output logic [edpc_pkg::OUT_TDATA_W-1:0]       m_tdata
);
	import edpc_pkg::*;

	logic                    valid_s1;
	in_beat_t                beat_s1;
	logic                    cv_s1;
	logic                    valid_s2;
	out_beat_t               res_s2;
	logic                    load_s1;
	logic                    adv_s1;

	logic signed [CNT_W-1:0] ref_q;
	logic                    held_q;
	logic                    long_done_q;
	logic [TIME_W-1:0]       press_time_q;
	logic [THR_W-1:0]        thr_q;

	logic signed [DET_W-1:0] det_raw;
	logic signed [CNT_W-1:0] ref_next;
	logic                    pressed;
	logic [TIME_W-1:0]       elapsed;
	out_beat_t               res_d;
	logic                    held_d;
	logic                    long_done_d;
	logic                    take_time;

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign load_s1  = s_tvalid && s_tready;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {(OUT_TDATA_W-OUT_FIELDS_W)'(0), res_s2};

	edpc_detent #(
		.DETENT_STEP(DETENT_STEP)
	) u_detent (
		.pulse_count(beat_s1.pulse_count),
		.ref_count  (ref_q),
		.detents    (det_raw),
		.ref_next   (ref_next)
	);

	always_comb begin
		pressed     = !beat_s1.button_level;
		elapsed     = beat_s1.time_us - press_time_q;
		held_d      = held_q;
		long_done_d = long_done_q;
		take_time   = 1'b0;
		res_d.detents     = cv_s1 ? det_raw : '0;
		res_d.short_press = 1'b0;
		res_d.long_press  = 1'b0;
		if (pressed && !held_q) begin
			held_d      = 1'b1;
			long_done_d = 1'b0;
			take_time   = 1'b1;
		end else if (held_q) begin
			if (!pressed) begin
				held_d            = 1'b0;
				res_d.short_press = !long_done_q;
			end else if (!long_done_q && (elapsed >= TIME_W'(thr_q))) begin
				long_done_d      = 1'b1;
				res_d.long_press = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			beat_s1 <= in_beat_t'(s_tdata[IN_FIELDS_W-1:0]);
			cv_s1   <= s_tuser;
		end
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q        <= '0;
			held_q       <= 1'b0;
			long_done_q  <= 1'b0;
			press_time_q <= '0;
			thr_q        <= THR_W'(LONG_PRESS_MS_RST * US_PER_MS);
		end else begin
			if (cfg_we) begin
				thr_q <= THR_W'(cfg_wdata) * THR_W'(US_PER_MS);
			end
			if (adv_s1) begin
				if (cv_s1) begin
					ref_q <= ref_next;
				end
				held_q      <= held_d;
				long_done_q <= long_done_d;
				if (take_time) begin
					press_time_q <= beat_s1.time_us;
				end
			end
		end
	end

	a_press_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.short_press && res_s2.long_press))
		else $error("short and long press in one result");

	a_long_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && res_d.long_press) |=> long_done_q)
		else $error("long press fired without latching");

	a_ref_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !cv_s1) |=> (ref_q == $past(ref_q)))
		else $error("reference moved on an invalid count");

	a_release_only: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && held_q && pressed) |=> held_q)
		else $error("button released while still pressed");

endmodule

`default_nettype wire

FILE: tb/edpc_checker.sv
// ----------------------------------------------------------------------------
// edpc_checker
// Watches the poll and result channels of the encoder detent and press
// classifier. Keeps its own copy of the reference count, button state and
// long-press threshold, works out the result due for every accepted poll
// beat, and compares each accepted result beat with the oldest one due.
// ----------------------------------------------------------------------------
module edpc_checker #(
	parameter int unsigned DETENT_STEP = edpc_pkg::DETENT_STEP_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [edpc_pkg::CFG_W-1:0]         cfg_wdata,  // hold threshold in ms
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	// pulse_count[15:0], button_level[16], time_us[64:17], zero pad
	input  logic [edpc_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic                               s_tuser,    // count_valid
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	// detents[14:0], short_press[15], long_press[16], zero pad
	input  logic [edpc_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output int                                 errors,
	output int                                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import edpc_pkg::*;

	localparam int STEP   = int'(DETENT_STEP);
	localparam int DET_HI = (1 << (DET_W - 1)) - 1;
	localparam int DET_LO = -(1 << (DET_W - 1));

	out_beat_t          results_due[$];
	int                 ref_pos;
	bit                 key_down;
	bit                 long_seen;
	logic [TIME_W-1:0]  press_at;
	logic [CFG_W-1:0]   hold_ms;
	int                 fail_cnt = 0;
	int                 shown = 0;

	assign errors = fail_cnt;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		fail_cnt++;
		if (shown < 40)
			$display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
		shown++;
	endtask

	function automatic out_beat_t classify_poll(input in_beat_t b, input logic cnt_ok);
		out_beat_t         o;
		int                cnt;
		int                q;
		logic [TIME_W-1:0] held_us;
		o = '0;
		q = 0;
		if (cnt_ok) begin
			cnt = $signed(b.pulse_count);
			q = (cnt - ref_pos) / STEP;
			if (q > DET_HI) q = DET_HI;
			if (q < DET_LO) q = DET_LO;
			ref_pos += q * STEP;
		end
		o.detents = q[DET_W-1:0];
		if (!b.button_level && !key_down) begin
			key_down = 1'b1;
			long_seen = 1'b0;
			press_at = b.time_us;
		end else if (key_down) begin
			if (b.button_level) begin
				key_down = 1'b0;
				o.short_press = !long_seen;
			end else if (!long_seen) begin
				held_us = b.time_us - press_at;
				if (held_us / US_PER_MS >= hold_ms) begin
					long_seen = 1'b1;
					o.long_press = 1'b1;
				end
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_beat_t got;
		out_beat_t want;
		if (!arst_n) begin
			ref_pos = 0;
			key_down = 1'b0;
			long_seen = 1'b0;
			press_at = '0;
			hold_ms = CFG_W'(LONG_PRESS_MS_RST);
			results_due.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[OUT_FIELDS_W-1:0];
				if (results_due.size() == 0) begin
					report_mismatch("result beat with nothing due, detents", got.detents, 0);
				end else begin
					want = results_due.pop_front();
					if (got.detents !== want.detents)
						report_mismatch("detents", got.detents, want.detents);
					if (got.short_press !== want.short_press)
						report_mismatch("short_press", got.short_press, want.short_press);
					if (got.long_press !== want.long_press)
						report_mismatch("long_press", got.long_press, want.long_press);
				end
			end
			if (cfg_we)
				hold_ms = cfg_wdata;
			if (s_tvalid && s_tready)
				results_due.push_back(classify_poll(s_tdata[IN_FIELDS_W-1:0], s_tuser));
			pending <= results_due.size();
		end
	end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives poll beats into the encoder detent and press classifier: a short
// directed run over count extremes, truncation, invalid counts, long and
// short presses, timer wrap and threshold extremes, then random press
// sequences with noise under several thresholds, with random gaps on both
// sides. The checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import edpc_pkg::*;

	localparam int unsigned RUN_LIMIT = 1_000_000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_W-1:0]        cfg_wdata = '0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata = '0;
	logic                    s_tuser = 1'b0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_tdata;
	int                      errors;
	int                      pending;

	bit                      tx_idle_on = 1'b1;
	bit                      rx_idle_on = 1'b1;
	int                      rx_hold = 0;
	int unsigned             polls = 0;
	int unsigned             cycles = 0;
	logic [CNT_W-1:0]        enc_pos = '0;
	logic [TIME_W-1:0]       now_us = '0;

	encoder_detent_and_press_classifier_core #(
		.DETENT_STEP(DETENT_STEP_DEF)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),  // hold threshold in ms
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // pulse_count, button_level, time_us, zero pad
		.s_tuser   (s_tuser),    // count_valid
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)     // detents, short_press, long_press, zero pad
	);

	edpc_checker #(
		.DETENT_STEP(DETENT_STEP_DEF)
	) chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin : rx_pace
		int n;
		if (rx_hold != 0) begin
			m_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else begin
			n = rx_idle_on ? pick_gap() : 0;
			m_tready <= (n == 0);
			rx_hold <= (n == 0) ? 0 : n - 1;
		end
	end

	task automatic poll(input logic [CNT_W-1:0] cnt, input logic cnt_ok, input logic lvl,
			input logic [TIME_W-1:0] t);
		in_beat_t b;
		int       n;
		b.pulse_count = cnt;
		b.button_level = lvl;
		b.time_us = t;
		n = tx_idle_on ? pick_gap() : 0;
		if (n != 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_W'(b);
		s_tuser <= cnt_ok;
		do @(posedge clk); while (!s_tready);
		polls++;
	endtask

	task automatic poll_walk(input logic lvl);
		logic ok;
		if ($urandom_range(0, 19) == 0)
			enc_pos = CNT_W'($urandom());
		else
			enc_pos = enc_pos + CNT_W'($urandom_range(0, 24)) - CNT_W'(12);
		ok = ($urandom_range(0, 7) != 0);
		poll(enc_pos, ok, lvl, now_us);
	endtask

	task automatic poll_noise();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		poll(r[63:48], 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), r[TIME_W-1:0]);
	endtask

	// idle ticks, press, a few held ticks over up to ~2x the threshold, often a release
	task automatic press_cycle(input logic [CFG_W-1:0] thr);
		int unsigned       lead;
		int unsigned       ticks;
		int unsigned       k;
		longint unsigned   span;
		longint unsigned   thr_us;
		logic [TIME_W-1:0] base;
		thr_us = longint'(thr) * US_PER_MS;
		lead = $urandom_range(0, 3);
		repeat (lead) begin
			now_us += TIME_W'($urandom_range(1, 50000));
			poll_walk(1'b1);
		end
		now_us += TIME_W'($urandom_range(1, 50000));
		base = now_us;
		poll_walk(1'b0);
		ticks = $urandom_range(0, 6);
		case ($urandom_range(0, 3))
			0: span = thr_us;
			1: span = (thr_us == 0) ? 0 : thr_us - 1;
			default: span = (thr_us * $urandom_range(0, 200)) / 100 + $urandom_range(0, 1999);
		endcase
		for (k = 1; k <= ticks; k++) begin
			now_us = base + TIME_W'(span * k / ticks);
			poll_walk(1'b0);
		end
		now_us += TIME_W'($urandom_range(1, 50000));
		if ($urandom_range(0, 7) != 0)
			poll_walk(1'b1);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_long_press(input logic [CFG_W-1:0] ms);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= ms;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned      ph;
		int unsigned      goal;
		logic [CFG_W-1:0] thr;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// rotation extremes, truncation toward zero, invalid count
		poll(16'h0000, 1'b1, 1'b1, 48'd0);
		poll(16'h7FFF, 1'b1, 1'b1, 48'd10);
		poll(16'h8000, 1'b1, 1'b1, 48'd20);
		poll(16'h8003, 1'b1, 1'b1, 48'd30);
		poll(16'h8004, 1'b1, 1'b1, 48'd40);
		poll(16'h0005, 1'b0, 1'b1, 48'd50);
		poll(16'h8002, 1'b1, 1'b1, 48'd60);
		poll(16'h8000, 1'b1, 1'b1, 48'd70);

		// long press at the reset threshold, then a short press
		poll(16'h8000, 1'b1, 1'b0, 48'd1_000_000);
		poll(16'h8000, 1'b1, 1'b0, 48'd1_599_999);
		poll(16'h8000, 1'b1, 1'b0, 48'd1_600_000);
		poll(16'h8000, 1'b1, 1'b1, 48'd5_000_010);
		poll(16'h8000, 1'b1, 1'b0, 48'd10_000_000);
		poll(16'h8000, 1'b1, 1'b1, 48'd10_000_100);
		poll(16'h8000, 1'b1, 1'b1, 48'd10_000_200);

		// hold across the timestamp wrap
		poll(16'h8000, 1'b0, 1'b0, 48'hFFFF_FFFF_FFFF - 48'd299_999);
		poll(16'h8000, 1'b0, 1'b0, 48'd300_000);
		poll(16'h8000, 1'b0, 1'b1, 48'd300_500);

		// zero threshold fires on the first held tick after the press
		set_long_press(16'd0);
		poll(16'h8000, 1'b1, 1'b0, 48'd100);
		poll(16'h8000, 1'b1, 1'b0, 48'd100);
		poll(16'h8000, 1'b1, 1'b1, 48'd200);

		set_long_press(16'hFFFF);
		poll(16'h8000, 1'b1, 1'b0, 48'd0);
		poll(16'h8000, 1'b1, 1'b0, 48'd65_534_999_999);
		poll(16'h8000, 1'b1, 1'b0, 48'd65_535_000_000);
		poll(16'h8000, 1'b1, 1'b1, 48'd65_535_000_001);
		now_us = 48'd70_000_000_000;

		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: thr = 16'd1;
				1: thr = 16'd600;
				2: thr = 16'hFFFF;
				3: thr = 16'd0;
				4: thr = CFG_W'($urandom_range(2, 65534));
				default: thr = CFG_W'($urandom_range(1, 3000));
			endcase
			set_long_press(thr);
			tx_idle_on = (ph % 3 != 0);
			rx_idle_on = (ph % 4 != 1);
			goal = polls + 300;
			while (polls < goal) begin
				if ($urandom_range(0, 9) == 0)
					poll_noise();
				else
					press_cycle(thr);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
